// ===== hdl/mmr_pkg.sv =====
// shared types, codes and helpers for the multicast membership report block
package mmr_pkg;

  localparam int AddrWidth     = 32;
  localparam int IntervalWidth = 16;
  localparam logic [IntervalWidth-1:0] DefaultInterval = IntervalWidth'(600);
  localparam logic [AddrWidth-1:0]     AllOnes         = '1;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_JOIN   = 2'd1,
    REQ_LEAVE  = 2'd2,
    REQ_REJOIN = 2'd3
  } req_type_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_SENDING = 4'b0010,
    ST_JOINED  = 4'b0100,
    ST_LEAVING = 4'b1000
  } fsm_state_t;

  localparam logic [1:0] CODE_IDLE    = 2'd0;
  localparam logic [1:0] CODE_SENDING = 2'd1;
  localparam logic [1:0] CODE_JOINED  = 2'd2;
  localparam logic [1:0] CODE_LEAVING = 2'd3;

  localparam logic REPORT_MEMBERSHIP = 1'b0;
  localparam logic REPORT_LEAVE      = 1'b1;

  typedef struct packed {
    fsm_state_t               fsm_state;
    logic [AddrWidth-1:0]     join_base;
    logic [AddrWidth-1:0]     join_mask;
    logic [AddrWidth-1:0]     leave_base;
    logic [AddrWidth-1:0]     leave_mask;
    logic [AddrWidth-1:0]     message_index;
    logic [IntervalWidth-1:0] tick_count;
    logic                     join_pending;
    logic                     leave_pending;
  } mmr_state_t;

  // external numbering of the one-hot states
  function automatic logic [1:0] state_code(fsm_state_t st);
    logic [1:0] code;
    unique case (st)
      ST_IDLE:    code = CODE_IDLE;
      ST_SENDING: code = CODE_SENDING;
      ST_JOINED:  code = CODE_JOINED;
      ST_LEAVING: code = CODE_LEAVING;
      default:    code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

// ===== hdl/multicast_membership_report_fsm.sv =====
// top level: multicast membership report state machine with stream ports
// an accepted request's result is registered and shown on the master side in the next cycle
// throughput: one request per cycle while the master side takes results; the state update sets the rate
// the result register frees whenever the downstream side takes or holds no result
// reset: synchronous rst returns the machine to idle with join and leave ranges
// cleared, masks all ones, counters zero and report_interval at 600
module multicast_membership_report_fsm (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [mmr_pkg::IntervalWidth-1:0]     cfg_data,      // report_interval
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [2*mmr_pkg::AddrWidth-1:0]       s_axis_tdata,  // group_base, group_mask
  input  logic [1:0]                            s_axis_tuser,  // req_type
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [39:0]                           m_axis_tdata,  // report_group, machine_state
  output logic [1:0]                            m_axis_tuser   // report_valid, report_kind
);
  import mmr_pkg::*;

  logic [IntervalWidth-1:0] report_interval;
  mmr_state_t               state;
  mmr_state_t               state_next;
  logic                     step_valid;
  logic                     step_kind;
  logic [AddrWidth-1:0]     step_group;
  logic                     in_fire;

  logic                     report_valid;
  logic                     report_kind;
  logic [AddrWidth-1:0]     report_group;
  logic [1:0]               machine_state;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  mmr_step u_step (
    .cur             (state),
    .req_type        (s_axis_tuser),
    .group_base      (s_axis_tdata[AddrWidth-1:0]),
    .group_mask      (s_axis_tdata[2*AddrWidth-1:AddrWidth]),
    .report_interval (report_interval),
    .nxt             (state_next),
    .report_valid    (step_valid),
    .report_kind     (step_kind),
    .report_group    (step_group)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      report_interval <= DefaultInterval;
    end else if (cfg_we) begin
      report_interval <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.fsm_state     <= ST_IDLE;
      state.join_base     <= '0;
      state.join_mask     <= AllOnes;
      state.leave_base    <= '0;
      state.leave_mask    <= AllOnes;
      state.message_index <= '0;
      state.tick_count    <= '0;
      state.join_pending  <= 1'b0;
      state.leave_pending <= 1'b0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // result payload, loaded with each accepted request
  always_ff @(posedge clk) begin
    if (in_fire) begin
      report_valid  <= step_valid;
      report_kind   <= step_kind;
      report_group  <= step_group;
      machine_state <= state_code(state_next.fsm_state);
    end
  end

  assign m_axis_tdata = {6'b0, machine_state, report_group};
  assign m_axis_tuser = {report_kind, report_valid};

endmodule

// ===== hdl/mmr_step.sv =====
// next-state and report logic for one tick or request
module mmr_step (
  input  mmr_pkg::mmr_state_t                 cur,
  input  logic [1:0]                          req_type,
  input  logic [mmr_pkg::AddrWidth-1:0]       group_base,
  input  logic [mmr_pkg::AddrWidth-1:0]       group_mask,
  input  logic [mmr_pkg::IntervalWidth-1:0]   report_interval,
  output mmr_pkg::mmr_state_t                 nxt,
  output logic                                report_valid,
  output logic                                report_kind,
  output logic [mmr_pkg::AddrWidth-1:0]       report_group
);
  import mmr_pkg::*;

  logic [IntervalWidth-1:0] tick_inc;
  logic [AddrWidth-1:0]     index_inc;
  req_type_t                req;

  assign tick_inc  = cur.tick_count + IntervalWidth'(1);
  assign index_inc = cur.message_index + AddrWidth'(1);
  assign req       = req_type_t'(req_type);

  always_comb begin
    nxt          = cur;
    report_valid = 1'b0;
    report_kind  = REPORT_MEMBERSHIP;
    report_group = '0;
    unique case (req)
      REQ_TICK: begin
        unique case (cur.fsm_state)
          ST_IDLE: begin
            nxt.message_index = '0;
            nxt.tick_count    = '0;
            nxt.leave_pending = 1'b0;
            if (cur.join_pending) begin
              nxt.join_pending = 1'b0;
              nxt.fsm_state    = ST_SENDING;
            end
          end
          ST_SENDING: begin
            // whole range sent once the index passes the free address bits
            if (cur.message_index > ~cur.join_mask) begin
              nxt.fsm_state = ST_JOINED;
            end else begin
              report_valid      = 1'b1;
              report_kind       = REPORT_MEMBERSHIP;
              report_group      = (cur.join_base & cur.join_mask) | cur.message_index;
              nxt.message_index = index_inc;
            end
          end
          ST_JOINED: begin
            nxt.message_index = '0;
            nxt.tick_count    = tick_inc;
            if (tick_inc >= report_interval) begin
              nxt.tick_count = '0;
              nxt.fsm_state  = ST_SENDING;
            end else if (cur.leave_pending) begin
              nxt.leave_pending = 1'b0;
              nxt.fsm_state     = ST_LEAVING;
            end else if (cur.join_pending) begin
              nxt.fsm_state = ST_LEAVING;
            end
          end
          default: begin
            if (cur.message_index > ~cur.leave_mask) begin
              nxt.fsm_state = ST_IDLE;
            end else begin
              report_valid      = 1'b1;
              report_kind       = REPORT_LEAVE;
              report_group      = (cur.leave_base & cur.leave_mask) | cur.message_index;
              nxt.message_index = index_inc;
            end
          end
        endcase
      end
      REQ_JOIN: begin
        if (cur.join_base != group_base || cur.join_mask != group_mask) begin
          nxt.leave_base   = cur.join_base;
          nxt.leave_mask   = cur.join_mask;
          nxt.join_base    = group_base;
          nxt.join_mask    = group_mask;
          nxt.join_pending = 1'b1;
        end
      end
      REQ_LEAVE: begin
        nxt.leave_pending = 1'b1;
        nxt.leave_base    = cur.join_base;
        nxt.leave_mask    = cur.join_mask;
        nxt.join_base     = '0;
        nxt.join_mask     = AllOnes;
      end
      default: begin
        if (cur.fsm_state == ST_JOINED || cur.fsm_state == ST_SENDING) begin
          nxt.join_pending = 1'b1;
          nxt.fsm_state    = ST_IDLE;
        end
      end
    endcase
  end

endmodule
